FILE: rtl/core/gifdec_pkg.sv
// Shared types and constants of the GIF LZW pixel decoder.
`default_nettype none
package gifdec_pkg;

  localparam int unsigned TableEntries = 4096;
  localparam int unsigned StackSlots   = TableEntries + 1;
  localparam logic [12:0] NoPrev       = 13'h1FFF;
  localparam logic [7:0]  AlphaOpaque  = 8'hFF;

  typedef enum logic [1:0] {
    OP_PAL_WRITE = 2'd0,
    OP_DECODE    = 2'd1,
    OP_START     = 2'd2,
    OP_NONE      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_RUNNING   = 3'd0,
    ST_ALL_ROWS  = 3'd1,
    ST_END_CODE  = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_BAD_CODE  = 3'd4,
    ST_TABLE_FULL = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    REG_ROOT_BITS   = 3'd0,
    REG_WIDTH       = 3'd1,
    REG_HEIGHT      = 3'd2,
    REG_INTERLACED  = 3'd3,
    REG_TRANSPARENT = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic        byte_taken;
    logic        pixel_valid;
    logic [31:0] pixel_color;
    logic [15:0] pixel_column;
    logic [15:0] pixel_row;
    logic [2:0]  status;
  } result_t;

  // Interlace pass start rows and row steps.
  function automatic logic [16:0] pass_start(input logic [1:0] pass);
    unique case (pass)
      2'd0: pass_start = 17'd0;
      2'd1: pass_start = 17'd4;
      2'd2: pass_start = 17'd2;
      default: pass_start = 17'd1;
    endcase
  endfunction

  function automatic logic [16:0] pass_step(input logic [1:0] pass);
    unique case (pass)
      2'd0: pass_step = 17'd8;
      2'd1: pass_step = 17'd8;
      2'd2: pass_step = 17'd4;
      default: pass_step = 17'd2;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/gif_lzw_pixel_decoder.sv
// GIF LZW pixel decoder: code unpacking, string table, symbol stack, palette.
//
// Usage: each input word carries an operation. Palette write stores one RGB
// entry; decode step does one step of the decoder (take a data byte, decode
// one code, or pop one pixel); start resets the decoder state and rewrites
// the root entries of the string table. Every input word yields exactly one
// output word, in order, with byte_taken, pixel fields and the stop status.
// Steps: a pixel pop reads the stack, then the palette; a first code after a clear
// reads its table entry; an appending code walks the chain with one table read per
// cycle; a start rewrites the root entries (2**root_bits, up to 256) before its
// output word. Other words go to the output register directly.
// One word is in flight at a time; the input is ready again as soon as the
// result sits in the output register, so a stalled receiver only holds the
// next word once that register is still full.
// Reset: all control state clears, configuration takes its reset values and
// a sweep of the 256 root entries runs with the input not ready; it produces no
// output word. The palette reads as zero until an entry is written.
// Configuration writes take effect at once; the user makes them only while idle, as the block does not enforce it.
`default_nettype none
module gif_lzw_pixel_decoder
  import gifdec_pkg::*;
#(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [1:0]  operation_i,
  input  wire logic [7:0]  palette_index_i,
  input  wire logic [23:0] palette_color_i,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        byte_available_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             byte_taken_o,
  output logic             pixel_valid_o,
  output logic [31:0]      pixel_color_o,
  output logic [15:0]      pixel_column_o,
  output logic [15:0]      pixel_row_o,
  output logic [2:0]       status_o
);

  localparam int unsigned PalAw = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam logic [2:0] S_SWEEP = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_TAIL  = 3'd4;
  localparam logic [2:0] S_FIRST = 3'd5;
  localparam logic [2:0] S_POP   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // Configuration registers
  logic [3:0]  root_bits_q;
  logic [15:0] image_width_q, image_height_q;
  logic        interlaced_q;
  logic [8:0]  transparent_q;

  // Decoder state
  logic [2:0]  state_q, state_d;
  logic        emit_after_q, emit_after_d;
  logic [7:0]  sweep_q, sweep_d;
  logic [19:0] bit_buf_q, bit_buf_d;
  logic [4:0]  bit_cnt_q, bit_cnt_d;
  logic [3:0]  code_w_q, code_w_d;
  logic [12:0] nfc_q, nfc_d;
  logic [12:0] prev_q, prev_d;
  logic [12:0] held_q, held_d;
  logic [12:0] cur_q, cur_d;
  logic [7:0]  first_q, first_d;
  logic [12:0] depth_q, depth_d;
  logic [15:0] col_q, col_d;
  logic [16:0] row_q, row_d;
  logic [15:0] rows_done_q, rows_done_d;
  logic [1:0]  pass_q, pass_d;
  logic [2:0]  stop_q, stop_d;
  logic        pop_phase_q, pop_phase_d;
  logic [7:0]  sym_q, sym_d;
  result_t     res_q, res_d;

  // Latched input word
  logic [1:0]  op_q;
  logic [7:0]  pidx_q, byte_q;
  logic [23:0] pcol_q;
  logic        avail_q;

  // Output register
  logic        out_valid_q;
  result_t     out_q;

  // Memories
  logic [11:0] prefix_mem [TableEntries];
  logic [7:0]  suffix_mem [TableEntries];
  logic [7:0]  stack_mem  [StackSlots];
  logic [23:0] pal_mem    [PALETTE_ENTRIES];
  logic [PALETTE_ENTRIES-1:0] pal_vld_q;

  logic        tab_we;
  logic [11:0] tab_waddr, tab_wpre, tab_raddr, pre_rd_q;
  logic [7:0]  tab_wsuf, suf_rd_q;
  logic        stk_we;
  logic [12:0] stk_waddr, stk_raddr;
  logic [7:0]  stk_wdata, stk_rd_q;
  logic        pal_we;
  logic [PalAw-1:0] pal_waddr, pal_raddr;
  logic [23:0] pal_rd_q;
  logic        pal_hit, pal_hit_q;

  logic [3:0]  eff_root;
  logic [8:0]  clr;

  always_comb begin
    if (root_bits_q < 4'd2) begin
      eff_root = 4'd2;
    end else if (root_bits_q > 4'd8) begin
      eff_root = 4'd8;
    end else begin
      eff_root = root_bits_q;
    end
  end
  assign clr = 9'd1 << eff_root;

  assign in_ready_o = (state_q == S_IDLE);

  // Main sequencer
  always_comb begin
    logic [11:0] msk;
    logic [12:0] cd, nxt, nfc_inc;
    logic [16:0] row_n;
    logic [31:0] colr;

    state_d      = state_q;
    emit_after_d = emit_after_q;
    sweep_d      = sweep_q;
    bit_buf_d    = bit_buf_q;
    bit_cnt_d    = bit_cnt_q;
    code_w_d     = code_w_q;
    nfc_d        = nfc_q;
    prev_d       = prev_q;
    held_d       = held_q;
    cur_d        = cur_q;
    first_d      = first_q;
    depth_d      = depth_q;
    col_d        = col_q;
    row_d        = row_q;
    rows_done_d  = rows_done_q;
    pass_d       = pass_q;
    stop_d       = stop_q;
    pop_phase_d  = pop_phase_q;
    sym_d        = sym_q;
    res_d        = res_q;

    tab_we    = 1'b0;
    tab_waddr = nfc_q[11:0];
    tab_wpre  = prev_q[11:0];
    tab_wsuf  = first_q;
    tab_raddr = cur_q[11:0];
    stk_we    = 1'b0;
    stk_waddr = depth_q;
    stk_wdata = first_q;
    stk_raddr = depth_q - 13'd1;
    pal_we    = 1'b0;
    pal_waddr = pidx_q[PalAw-1:0];
    pal_raddr = sym_q[PalAw-1:0];

    msk     = 12'((13'd1 << code_w_q) - 13'd1);
    cd      = {1'b0, bit_buf_q[11:0] & msk};
    nxt     = {1'b0, pre_rd_q};
    nfc_inc = nfc_q + 13'd1;
    row_n   = '0;
    colr    = '0;

    unique case (state_q)
      // Write root entries one per cycle
      S_SWEEP: begin
        tab_we    = 1'b1;
        tab_waddr = {4'd0, sweep_q};
        tab_wpre  = '0;
        tab_wsuf  = sweep_q;
        sweep_d   = sweep_q + 8'd1;
        if ({1'b0, sweep_q} == clr - 9'd1) begin
          sweep_d = '0;
          res_d   = '0;
          res_d.status = stop_q;
          state_d = emit_after_q ? S_EMIT : S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        res_d   = '0;
        state_d = S_EMIT;
        unique case (op_e'(op_q))
          OP_PAL_WRITE: begin
            pal_we = ({1'b0, pidx_q} < 9'(PALETTE_ENTRIES));
          end
          OP_START: begin
            bit_buf_d   = '0;
            bit_cnt_d   = '0;
            code_w_d    = eff_root + 4'd1;
            nfc_d       = {4'd0, clr} + 13'd2;
            prev_d      = NoPrev;
            first_d     = '0;
            depth_d     = '0;
            col_d       = '0;
            row_d       = '0;
            rows_done_d = '0;
            pass_d      = '0;
            stop_d      = ST_RUNNING;
            sweep_d     = '0;
            emit_after_d = 1'b1;
            state_d     = S_SWEEP;
          end
          OP_DECODE: begin
            priority if (stop_q != ST_RUNNING) begin
            end else if (image_width_q == '0 || rows_done_q >= image_height_q) begin
              stop_d = ST_ALL_ROWS;
            end else if (depth_q != '0) begin
              // Pop: read the stack top, then the palette
              depth_d     = depth_q - 13'd1;
              pop_phase_d = 1'b0;
              state_d     = S_POP;
            end else if ({1'b0, bit_cnt_q} < {2'b0, code_w_q}) begin
              if (avail_q) begin
                bit_buf_d = bit_buf_q | (20'(byte_q) << bit_cnt_q);
                bit_cnt_d = bit_cnt_q + 5'd8;
                res_d.byte_taken = 1'b1;
              end else begin
                stop_d = ST_EXHAUSTED;
              end
            end else begin
              bit_buf_d = bit_buf_q >> code_w_q;
              bit_cnt_d = bit_cnt_q - {1'b0, code_w_q};
              priority if (cd > nfc_q) begin
                stop_d = ST_BAD_CODE;
              end else if (cd == {4'd0, clr} + 13'd1) begin
                stop_d = ST_END_CODE;
              end else if (cd == {4'd0, clr}) begin
                code_w_d = eff_root + 4'd1;
                nfc_d    = {4'd0, clr} + 13'd2;
                prev_d   = NoPrev;
              end else if (prev_q == NoPrev) begin
                tab_raddr = cd[11:0];
                cur_d     = cd;
                state_d   = S_FIRST;
              end else begin
                held_d = cd;
                cur_d  = cd;
                if (cd >= nfc_q) begin
                  // Code not yet in the table: repeat first symbol
                  stk_we    = 1'b1;
                  stk_wdata = first_q;
                  depth_d   = depth_q + 13'd1;
                  cur_d     = prev_q;
                end
                tab_raddr = cur_d[11:0];
                state_d   = (cur_d >= {4'd0, clr}) ? S_WALK : S_TAIL;
              end
            end
          end
          default: begin
          end
        endcase
        res_d.status = stop_d;
      end

      // First code after a clear: push its suffix
      S_FIRST: begin
        stk_we    = 1'b1;
        stk_wdata = suf_rd_q;
        depth_d   = depth_q + 13'd1;
        prev_d    = cur_q;
        first_d   = cur_q[7:0];
        res_d.status = stop_q;
        state_d   = S_EMIT;
      end

      // Follow the string chain one link per cycle
      S_WALK: begin
        if (depth_q >= 13'(StackSlots)) begin
          stop_d = ST_BAD_CODE;
          res_d.status = ST_BAD_CODE;
          state_d = S_EMIT;
        end else begin
          stk_we    = 1'b1;
          stk_wdata = suf_rd_q;
          depth_d   = depth_q + 13'd1;
          cur_d     = nxt;
          tab_raddr = nxt[11:0];
          if (nxt < {4'd0, clr}) begin
            state_d = S_TAIL;
          end
        end
      end

      // Root reached: push it and append the new table entry, unless table or stack is full
      S_TAIL: begin
        first_d = suf_rd_q;
        state_d = S_EMIT;
        priority if (nfc_q >= 13'(TableEntries)) begin
          stop_d = ST_TABLE_FULL;
        end else if (depth_q >= 13'(StackSlots)) begin
          stop_d = ST_BAD_CODE;
        end else begin
          stk_we    = 1'b1;
          stk_wdata = suf_rd_q;
          depth_d   = depth_q + 13'd1;
          tab_we    = 1'b1;
          tab_waddr = nfc_q[11:0];
          tab_wpre  = prev_q[11:0];
          tab_wsuf  = suf_rd_q;
          nfc_d     = nfc_inc;
          if ((nfc_inc[11:0] & msk) == '0 && nfc_inc < 13'(TableEntries)) begin
            code_w_d = code_w_q + 4'd1;
          end
          prev_d = held_q;
        end
        res_d.status = stop_d;
      end

      S_POP: begin
        if (!pop_phase_q) begin
          sym_d       = stk_rd_q;
          pal_raddr   = stk_rd_q[PalAw-1:0];
          pop_phase_d = 1'b1;
        end else begin
          colr = {AlphaOpaque, pal_hit_q ? pal_rd_q : 24'd0};
          if (!transparent_q[8] && sym_q == transparent_q[7:0]) begin
            colr = '0;
          end
          res_d.pixel_valid  = 1'b1;
          res_d.pixel_color  = colr;
          res_d.pixel_column = col_q;
          res_d.pixel_row    = row_q[15:0];
          col_d = col_q + 16'd1;
          if (col_d >= image_width_q) begin
            col_d       = '0;
            rows_done_d = rows_done_q + 16'd1;
            if (!interlaced_q) begin
              row_d = row_q + 17'd1;
            end else begin
              row_n  = row_q + pass_step(pass_q);
              pass_d = pass_q;
              // Skip passes that start below the image
              for (int k = 0; k < 3; k++) begin
                if (row_n >= {1'b0, image_height_q} && pass_d != 2'd3) begin
                  pass_d = pass_d + 2'd1;
                  row_n  = pass_start(pass_d);
                end
              end
              row_d = row_n;
            end
            if (rows_done_d >= image_height_q) begin
              stop_d = ST_ALL_ROWS;
            end
          end
          res_d.status = stop_d;
          state_d = S_EMIT;
        end
      end

      // Hand the result to the output register
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign pal_hit = ({1'b0, pal_raddr} < 9'(PALETTE_ENTRIES)) && pal_vld_q[pal_raddr] &&
                   ({1'b0, sym_d} < 9'(PALETTE_ENTRIES));

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_SWEEP;
      emit_after_q <= 1'b0;
      sweep_q      <= '0;
      bit_buf_q    <= '0;
      bit_cnt_q    <= '0;
      code_w_q     <= 4'd9;
      nfc_q        <= 13'd258;
      prev_q       <= NoPrev;
      held_q       <= '0;
      cur_q        <= '0;
      first_q      <= '0;
      depth_q      <= '0;
      col_q        <= '0;
      row_q        <= '0;
      rows_done_q  <= '0;
      pass_q       <= '0;
      stop_q       <= ST_RUNNING;
      pop_phase_q  <= 1'b0;
      out_valid_q  <= 1'b0;
      pal_vld_q    <= '0;
      root_bits_q  <= 4'd8;
      image_width_q  <= 16'd1;
      image_height_q <= 16'd1;
      interlaced_q   <= 1'b0;
      transparent_q  <= 9'h1FF;
    end else begin
      state_q      <= state_d;
      emit_after_q <= emit_after_d;
      sweep_q      <= sweep_d;
      bit_buf_q    <= bit_buf_d;
      bit_cnt_q    <= bit_cnt_d;
      code_w_q     <= code_w_d;
      nfc_q        <= nfc_d;
      prev_q       <= prev_d;
      held_q       <= held_d;
      cur_q        <= cur_d;
      first_q      <= first_d;
      depth_q      <= depth_d;
      col_q        <= col_d;
      row_q        <= row_d;
      rows_done_q  <= rows_done_d;
      pass_q       <= pass_d;
      stop_q       <= stop_d;
      pop_phase_q  <= pop_phase_d;
      if (pal_we) begin
        pal_vld_q[pal_waddr] <= 1'b1;
      end
      if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_ROOT_BITS:   root_bits_q    <= cfg_data_i[3:0];
          REG_WIDTH:       image_width_q  <= cfg_data_i;
          REG_HEIGHT:      image_height_q <= cfg_data_i;
          REG_INTERLACED:  interlaced_q   <= cfg_data_i[0];
          REG_TRANSPARENT: transparent_q  <= cfg_data_i[8:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    sym_q <= sym_d;
    res_q <= res_d;
    if (in_valid_i && in_ready_o) begin
      op_q    <= operation_i;
      pidx_q  <= palette_index_i;
      pcol_q  <= palette_color_i;
      byte_q  <= data_byte_i;
      avail_q <= byte_available_i;
    end
    if (state_q == S_EMIT && (!out_valid_q || out_ready_i)) begin
      out_q <= res_q;
    end
  end

  // String table memories
  always_ff @(posedge clk_i) begin
    if (tab_we) begin
      prefix_mem[tab_waddr] <= tab_wpre;
      suffix_mem[tab_waddr] <= tab_wsuf;
    end
    pre_rd_q <= prefix_mem[tab_raddr];
    suf_rd_q <= suffix_mem[tab_raddr];
  end

  // Symbol stack memory
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd_q <= stack_mem[stk_raddr];
  end

  // Palette memory
  always_ff @(posedge clk_i) begin
    if (pal_we) begin
      pal_mem[pal_waddr] <= pcol_q;
    end
    pal_rd_q  <= pal_mem[pal_raddr];
    pal_hit_q <= pal_hit;
  end

  assign out_valid_o    = out_valid_q;
  assign byte_taken_o   = out_q.byte_taken;
  assign pixel_valid_o  = out_q.pixel_valid;
  assign pixel_color_o  = out_q.pixel_color;
  assign pixel_column_o = out_q.pixel_column;
  assign pixel_row_o    = out_q.pixel_row;
  assign status_o       = out_q.status;

`ifndef NO_ASSERTIONS
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= 13'(StackSlots))
    else $error("symbol stack depth beyond capacity");
  a_code_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    code_w_q >= 4'd3 && code_w_q <= 4'd12)
    else $error("code width out of range");
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input accepted while a word is in flight");
  a_emit_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished word not loaded into output register");
`endif

endmodule
`default_nettype wire

FILE: sim/gif_decode_checker.sv
// Checker for the GIF LZW pixel decoder: predicts every output word and compares.
module gif_decode_checker
  import gifdec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [1:0]  operation_i,
  input  logic [7:0]  palette_index_i,
  input  logic [23:0] palette_color_i,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_available_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic        byte_taken_i,
  input  logic        pixel_valid_i,
  input  logic [31:0] pixel_color_i,
  input  logic [15:0] pixel_column_i,
  input  logic [15:0] pixel_row_i,
  input  logic [2:0]  status_i,
  output int          fail_count_o,
  output int          words_owed_o
);

  localparam int unsigned PassFirst [4] = '{0, 4, 2, 1};
  localparam int unsigned PassStride[4] = '{8, 8, 4, 2};

  // Configuration copy
  int unsigned root_bits_q, width_q, height_q, interlaced_q;
  logic [8:0]  transp_q;

  // Decoder state copy
  int unsigned bit_buf, bit_cnt, code_w, next_code, prev_code;
  logic [7:0]  first_sym;
  logic [11:0] prefix_mem[TableEntries];
  logic [7:0]  suffix_mem[TableEntries];
  logic [7:0]  stack_mem[StackSlots];
  int unsigned depth;
  logic [23:0] pal_mem[256];
  int unsigned col_cnt, row_off, rows_done, pass_idx, stop_code;

  result_t owed_q[$];
  int      fails;

  assign fail_count_o = fails;
  assign words_owed_o = owed_q.size();

  function automatic int unsigned root_eff();
    if (root_bits_q < 2) return 2;
    if (root_bits_q > 8) return 8;
    return root_bits_q;
  endfunction

  // Restart the frame and rewrite the root entries
  function automatic void start_frame();
    int unsigned rb;
    rb = root_eff();
    bit_buf = 0;
    bit_cnt = 0;
    code_w = rb + 1;
    next_code = (1 << rb) + 2;
    prev_code = NoPrev;
    first_sym = 8'd0;
    depth = 0;
    col_cnt = 0;
    row_off = 0;
    rows_done = 0;
    pass_idx = 0;
    stop_code = ST_RUNNING;
    for (int j = 0; j < (1 << rb); j++) begin
      prefix_mem[j] = 12'd0;
      suffix_mem[j] = j[7:0];
    end
  endfunction

  function automatic bit push_symbol(input logic [7:0] s);
    if (depth >= StackSlots) return 1'b0;
    stack_mem[depth] = s;
    depth++;
    return 1'b1;
  endfunction

  // Unpack one code and walk its string onto the stack
  function automatic void decode_code();
    int unsigned rb, clr, msk, cd, cur, held;
    rb = root_eff();
    clr = 1 << rb;
    msk = (1 << code_w) - 1;
    cd = bit_buf & msk;
    bit_buf = bit_buf >> code_w;
    bit_cnt = bit_cnt - code_w;
    if (cd > next_code) begin
      stop_code = ST_BAD_CODE;
      return;
    end
    if (cd == clr + 1) begin
      stop_code = ST_END_CODE;
      return;
    end
    if (cd == clr) begin
      code_w = rb + 1;
      next_code = clr + 2;
      prev_code = NoPrev;
      return;
    end
    if (prev_code == NoPrev) begin
      void'(push_symbol(suffix_mem[cd & 4095]));
      prev_code = cd;
      first_sym = cd[7:0];
      return;
    end
    held = cd;
    cur = cd;
    if (cur >= next_code) begin
      if (!push_symbol(first_sym)) begin
        stop_code = ST_BAD_CODE;
        return;
      end
      cur = prev_code;
    end
    while (cur >= clr) begin
      if (!push_symbol(suffix_mem[cur & 4095])) begin
        stop_code = ST_BAD_CODE;
        return;
      end
      cur = prefix_mem[cur & 4095];
    end
    first_sym = suffix_mem[cur & 4095];
    if (next_code >= TableEntries) begin
      stop_code = ST_TABLE_FULL;
      return;
    end
    if (!push_symbol(first_sym)) begin
      stop_code = ST_BAD_CODE;
      return;
    end
    prefix_mem[next_code & 4095] = prev_code[11:0];
    suffix_mem[next_code & 4095] = first_sym;
    next_code++;
    if (((next_code & msk) == 0) && (next_code < TableEntries)) code_w++;
    prev_code = held;
  endfunction

  // Pop one index, color it and advance column and row
  function automatic result_t pop_pixel();
    result_t r;
    logic [7:0] sym;
    r = '0;
    depth--;
    sym = stack_mem[depth];
    r.pixel_valid = 1'b1;
    r.pixel_color = {AlphaOpaque, pal_mem[sym]};
    if (!transp_q[8] && sym == transp_q[7:0]) r.pixel_color = 32'd0;
    r.pixel_column = col_cnt[15:0];
    r.pixel_row = row_off[15:0];
    col_cnt++;
    if (col_cnt >= width_q) begin
      col_cnt = 0;
      rows_done++;
      if (interlaced_q == 0) begin
        row_off++;
      end else begin
        row_off += PassStride[pass_idx];
        while (row_off >= height_q && pass_idx < 3) begin
          pass_idx++;
          row_off = PassFirst[pass_idx];
        end
      end
      if (rows_done >= height_q) stop_code = ST_ALL_ROWS;
    end
    return r;
  endfunction

  function automatic result_t decode_word(input logic [1:0] op, input logic [7:0] pidx,
                                          input logic [23:0] pcol, input logic [7:0] dbyte,
                                          input logic avail);
    result_t r;
    r = '0;
    case (op)
      OP_PAL_WRITE: pal_mem[pidx] = pcol;
      OP_START: start_frame();
      OP_DECODE: begin
        if (stop_code == ST_RUNNING) begin
          if (width_q == 0 || rows_done >= height_q) begin
            stop_code = ST_ALL_ROWS;
          end else if (depth == 0) begin
            if (bit_cnt < code_w) begin
              if (avail) begin
                bit_buf = (bit_buf | (int'(dbyte) << bit_cnt)) & 32'hFFFFF;
                bit_cnt += 8;
                r.byte_taken = 1'b1;
              end else begin
                stop_code = ST_EXHAUSTED;
              end
            end else begin
              decode_code();
            end
          end else begin
            r = pop_pixel();
          end
        end
      end
      default: ;
    endcase
    r.status = stop_code[2:0];
    return r;
  endfunction

  function automatic void check_field(input string fld, input logic [31:0] e,
                                      input logic [31:0] a);
    if (e !== a) begin
      fails++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, fld, e, a);
    end
  endfunction

  // Predict on accepted input words, compare on accepted output words
  always @(posedge clk_i or negedge rst_ni) begin
    result_t exp_w;
    if (!rst_ni) begin
      root_bits_q = 8;
      width_q = 1;
      height_q = 1;
      interlaced_q = 0;
      transp_q = 9'h1FF;
      for (int j = 0; j < TableEntries; j++) begin
        prefix_mem[j] = 12'd0;
        suffix_mem[j] = 8'd0;
      end
      for (int j = 0; j < 256; j++) pal_mem[j] = 24'd0;
      start_frame();
      owed_q.delete();
      fails = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_ROOT_BITS:   root_bits_q = cfg_data_i[3:0];
          REG_WIDTH:       width_q = cfg_data_i;
          REG_HEIGHT:      height_q = cfg_data_i;
          REG_INTERLACED:  interlaced_q = cfg_data_i[0];
          REG_TRANSPARENT: transp_q = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        owed_q.push_back(decode_word(operation_i, palette_index_i, palette_color_i,
                                     data_byte_i, byte_available_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (owed_q.size() == 0) begin
          fails++;
          $display("%0t: unexpected word: expected none, got status %h pixel %h",
                   $time, status_i, pixel_color_i);
        end else begin
          exp_w = owed_q.pop_front();
          check_field("byte_taken", exp_w.byte_taken, byte_taken_i);
          check_field("pixel_valid", exp_w.pixel_valid, pixel_valid_i);
          check_field("pixel_color", exp_w.pixel_color, pixel_color_i);
          check_field("pixel_column", exp_w.pixel_column, pixel_column_i);
          check_field("pixel_row", exp_w.pixel_row, pixel_row_i);
          check_field("status", exp_w.status, status_i);
        end
      end
    end
  end

endmodule

FILE: sim/tb_top.sv
// Stimulus and verdict for the GIF LZW pixel decoder.
module tb_top;
  import gifdec_pkg::*;

  localparam int WordTarget = 1850;
  localparam int StallLimit = 20000;

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i, in_ready_o;
  logic [1:0]  operation_i;
  logic [7:0]  palette_index_i;
  logic [23:0] palette_color_i;
  logic [7:0]  data_byte_i;
  logic        byte_available_i;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        byte_taken_o, pixel_valid_o;
  logic [31:0] pixel_color_o;
  logic [15:0] pixel_column_o, pixel_row_o;
  logic [2:0]  status_o;
  int          fail_count, words_owed;

  int          words_in = 0, words_out = 0, quiet_cycles = 0;
  int          idle_pct = 0, stall_pct = 0;
  logic        last_taken = 1'b0;
  logic [2:0]  last_status = ST_RUNNING;

  // LZW stream under construction
  logic [7:0]      lzw_bytes[$];
  longint unsigned pack_acc;
  int unsigned     pack_bits, pack_w;

  gif_lzw_pixel_decoder uut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_o, .operation_i, .palette_index_i, .palette_color_i,
    .data_byte_i, .byte_available_i, .out_valid_o, .out_ready_i,
    .byte_taken_o, .pixel_valid_o, .pixel_color_o, .pixel_column_o, .pixel_row_o,
    .status_o
  );

  gif_decode_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .in_valid_i, .in_ready_i(in_ready_o), .operation_i, .palette_index_i,
    .palette_color_i, .data_byte_i, .byte_available_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .byte_taken_i(byte_taken_o), .pixel_valid_i(pixel_valid_o),
    .pixel_color_i(pixel_color_o), .pixel_column_i(pixel_column_o),
    .pixel_row_i(pixel_row_o), .status_i(status_o),
    .fail_count_o(fail_count), .words_owed_o(words_owed)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Count words, track the last result and guard against a hang
  always @(posedge clk_i) begin
    bit moved;
    moved = 1'b0;
    if (in_valid_i && in_ready_o) begin
      words_in++;
      moved = 1'b1;
    end
    if (out_valid_o && out_ready_i) begin
      words_out++;
      last_taken = byte_taken_o;
      last_status = status_o;
      moved = 1'b1;
    end
    quiet_cycles = moved ? 0 : quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Test completed with failures");
      $finish;
    end
    case (words_in * 4 / WordTarget)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 62; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 62; end
      default: begin idle_pct = 33; stall_pct = 33; end
    endcase
  end

  // Receiver stalls
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
  end

  // Offer one word and hold it until accepted
  task automatic send_word(input op_e op, input logic [7:0] pidx, input logic [23:0] pcol,
                           input logic [7:0] db, input logic av);
    bit hs;
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    palette_index_i <= pidx;
    palette_color_i <= pcol;
    data_byte_i <= db;
    byte_available_i <= av;
    hs = 1'b0;
    while (!hs) begin
      @(negedge clk_i);
      hs = in_ready_o;
      @(posedge clk_i);
    end
  endtask

  // Hold off until every word has come back
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (words_in != words_out);
    @(posedge clk_i);
  endtask

  task automatic configure(input int unsigned rb, input int unsigned w, input int unsigned h,
                           input int unsigned il, input int unsigned ti);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_ROOT_BITS;   cfg_data_i <= 16'(rb);  @(posedge clk_i);
    cfg_index_i <= REG_WIDTH;       cfg_data_i <= 16'(w);   @(posedge clk_i);
    cfg_index_i <= REG_HEIGHT;      cfg_data_i <= 16'(h);   @(posedge clk_i);
    cfg_index_i <= REG_INTERLACED;  cfg_data_i <= 16'(il);  @(posedge clk_i);
    cfg_index_i <= REG_TRANSPARENT; cfg_data_i <= 16'(ti);  @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic void pack_code(input int unsigned code);
    pack_acc = pack_acc | (longint'(code) << pack_bits);
    pack_bits += pack_w;
    while (pack_bits >= 8) begin
      lzw_bytes.push_back(pack_acc[7:0]);
      pack_acc = pack_acc >> 8;
      pack_bits -= 8;
    end
  endfunction

  // Encode a random code sequence, mostly well-formed but sometimes ending in a bad code, mirroring width growth
  function automatic void build_stream(input int unsigned rb, input int unsigned ncodes);
    int unsigned clr, nf, code;
    bit first, broken, ended;
    clr = 1 << rb;
    nf = clr + 2;
    first = 1'b1;
    broken = 1'b0;
    ended = 1'b0;
    lzw_bytes.delete();
    pack_acc = 0;
    pack_bits = 0;
    pack_w = rb + 1;
    if ($urandom_range(1)) pack_code(clr);
    for (int i = 0; i < ncodes && !broken; i++) begin
      if (!first && $urandom_range(29) == 0) begin
        pack_code(clr);
        pack_w = rb + 1;
        nf = clr + 2;
        first = 1'b1;
      end else if (first) begin
        pack_code($urandom_range(clr - 1));
        first = 1'b0;
      end else if ($urandom_range(39) == 0 && nf + 1 < (1 << pack_w)) begin
        pack_code(nf + 1);
        broken = 1'b1;
      end else begin
        code = $urandom_range(nf);
        if (code == clr || code == clr + 1) code = nf;
        pack_code(code);
        nf++;
        if (((nf & ((1 << (pack_w - (((nf - 1) & ((1 << pack_w) - 1)) == ((1 << pack_w) - 1)
             ? 0 : 0))) - 1)) == 0) && nf < TableEntries) pack_w++;
      end
    end
    if (!broken && $urandom_range(9) != 0) begin
      pack_code(clr + 1);
      ended = 1'b1;
    end else if (first && !broken) begin
      // A stream cut right after a clear still gets its first root code
      pack_code($urandom_range(clr - 1));
    end
    if (pack_bits > 0) lzw_bytes.push_back(pack_acc[7:0]);
    // Trailing junk only behind an end code, where it is never decoded
    if (ended && $urandom_range(1)) lzw_bytes.push_back(8'($urandom_range(255)));
  endfunction

  // Step the decoder through one frame, feeding bytes as they are taken
  task automatic run_frame();
    int unsigned ptr, navail, r;
    bit done;
    ptr = 0;
    done = 1'b0;
    navail = lzw_bytes.size();
    if ($urandom_range(7) == 0) navail = $urandom_range(navail);
    while (!done) begin
      r = $urandom_range(99);
      if (r < 3) begin
        send_word(OP_NONE, 8'($urandom_range(255)), 24'($urandom), 8'($urandom_range(255)),
                  1'($urandom_range(1)));
      end else if (r < 6) begin
        send_word(OP_PAL_WRITE, 8'($urandom_range(255)), 24'($urandom),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_word(OP_DECODE, 8'($urandom_range(255)), 24'($urandom),
                  (ptr < navail) ? lzw_bytes[ptr] : 8'($urandom_range(255)), ptr < navail);
      end
      settle();
      if (last_taken) ptr++;
      if (last_status != ST_RUNNING) done = 1'b1;
    end
    if ($urandom_range(4) == 0) begin
      send_word(OP_DECODE, 8'($urandom_range(255)), 24'($urandom), 8'($urandom_range(255)),
                1'b1);
    end
  endtask

  initial begin
    int unsigned rb, rbe, w, h, il, ti, frame;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    operation_i = OP_NONE;
    palette_index_i = '0;
    palette_color_i = '0;
    data_byte_i = '0;
    byte_available_i = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Wait out the root sweep after reset
    do @(negedge clk_i); while (in_ready_o !== 1'b1);
    @(posedge clk_i);

    // Directed: empty frame, palette extremes, unused op, no data offered
    configure(8, 0, 1, 0, 0);
    send_word(OP_START, 8'h00, 24'h0, 8'h00, 1'b0);
    send_word(OP_DECODE, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b1);
    send_word(OP_DECODE, 8'h00, 24'h0, 8'h00, 1'b1);
    send_word(OP_PAL_WRITE, 8'h00, 24'hFFFFFF, 8'h00, 1'b0);
    send_word(OP_PAL_WRITE, 8'hFF, 24'h000000, 8'hFF, 1'b1);
    send_word(OP_PAL_WRITE, 8'hAA, 24'h555555, 8'hAA, 1'b0);
    send_word(OP_PAL_WRITE, 8'h55, 24'hAAAAAA, 8'h55, 1'b1);
    send_word(OP_NONE, 8'hFF, 24'hFFFFFF, 8'hFF, 1'b1);
    settle();
    configure(2, 1, 1, 0, 0);
    send_word(OP_START, 8'h00, 24'h0, 8'h00, 1'b0);
    send_word(OP_DECODE, 8'h00, 24'h0, 8'h00, 1'b0);
    settle();

    // Frames: extremes first, then random settings
    frame = 0;
    while (words_in < WordTarget) begin
      case (frame)
        0: begin rb = 0;  w = 65535; h = 65535; il = 1; ti = 9'h1FF; end
        1: begin rb = 15; w = 1;     h = 1;     il = 0; ti = 255;    end
        2: begin rb = 8;  w = 3;     h = 11;    il = 1; ti = 0;      end
        3: begin rb = 1;  w = 2;     h = 9;     il = 1; ti = 1;      end
        default: begin
          rb = $urandom_range(15);
          w = ($urandom_range(19) == 0) ? 65535 : $urandom_range(1, 8);
          h = ($urandom_range(19) == 0) ? 65535 : $urandom_range(1, 12);
          il = $urandom_range(1);
          ti = 0;
        end
      endcase
      rbe = (rb < 2) ? 2 : ((rb > 8) ? 8 : rb);
      if (frame > 3) begin
        case ($urandom_range(2))
          0: ti = 9'h1FF;
          1: ti = $urandom_range((1 << rbe) - 1);
          default: ti = $urandom_range(255);
        endcase
      end
      settle();
      configure(rb, w, h, il, ti);
      send_word(OP_START, 8'($urandom_range(255)), 24'($urandom), 8'($urandom_range(255)),
                1'($urandom_range(1)));
      repeat ($urandom_range(6)) begin
        send_word(OP_PAL_WRITE, 8'($urandom_range((1 << rbe) - 1)), 24'($urandom),
                  8'($urandom_range(255)), 1'($urandom_range(1)));
      end
      settle();
      build_stream(rbe, $urandom_range(3, 24));
      run_frame();
      frame++;
    end

    // Drain and let the pipeline go quiet
    settle();
    repeat (300) @(posedge clk_i);
    if (fail_count == 0 && words_owed == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
